// ===== rtl/asl_pkg.sv =====
// asl_pkg: shared types and constants of the assembly source lexer
// transfer payload structs, token type codes, default limits
// no dependencies
package asl_pkg;

    localparam int STRING_MAX_DEF = 254;
    localparam int IDENT_MAX_DEF  = 63;
    localparam int OUTQ_DEPTH     = 4;

    typedef enum logic [2:0] {
        TOK_NUM   = 3'd0,
        TOK_STR   = 3'd1,
        TOK_IDENT = 3'd2,
        TOK_LABEL = 3'd3,
        TOK_END   = 3'd4,
        TOK_ERR   = 3'd5
    } tok_type_t;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } asl_in_t;

    typedef struct packed {
        logic               kind;
        logic [2:0]         token_type;
        logic [7:0]         text_byte;
        logic signed [31:0] token_value;
        logic [23:0]        line_number;
        logic               was_truncated;
        logic               last_of_run;
    } asl_out_t;

    // results of one step, handed from the lexer core to the output queue
    typedef struct packed {
        logic [1:0] cnt;
        asl_out_t   r0;
        asl_out_t   r1;
    } asl_push_t;

endpackage

// ===== rtl/asl_core.sv =====
// asl_core: lexer state registers and the per-byte next-state logic
// produces up to two results per step
// depends on asl_pkg
module asl_core #(
    parameter int STRING_MAX = asl_pkg::STRING_MAX_DEF,
    parameter int IDENT_MAX  = asl_pkg::IDENT_MAX_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               step,
    input  asl_pkg::asl_in_t   in_data,
    output asl_pkg::asl_push_t push
);
    import asl_pkg::*;

    localparam logic [23:0] LINE_MAX = 24'hFFFFFF;

    typedef enum logic [3:0] {
        M_IDLE      = 4'd0,
        M_COMMENT   = 4'd1,
        M_CHR_OPEN  = 4'd2,
        M_CHR_ESC   = 4'd3,
        M_CHR_CLOSE = 4'd4,
        M_STR       = 4'd5,
        M_STR_ESC   = 4'd6,
        M_STR_SKIP  = 4'd7,
        M_IDENT     = 4'd8,
        M_NUM_SIGN  = 4'd9,
        M_NUM_ZERO  = 4'd10,
        M_NUM_DEC   = 4'd11,
        M_NUM_HEX   = 4'd12
    } mode_t;

    typedef struct packed {
        mode_t       mode;
        logic [31:0] acc;
        logic        neg;
        logic [7:0]  tlen;
        logic [3:0]  alias_trk;
        logic [23:0] cur_line;
        logic [23:0] start_line;
        logic [31:0] total;
        logic        err;
    } state_t;

    localparam state_t RESET_STATE = '{
        mode: M_IDLE, acc: 32'd0, neg: 1'b0, tlen: 8'd0, alias_trk: 4'd0,
        cur_line: 24'd1, start_line: 24'd1, total: 32'd0, err: 1'b0
    };

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return is_alpha(c) || is_digit(c) || c == "_" || c == ".";
    endfunction

    function automatic logic [7:0] upper(input logic [7:0] c);
        return (c >= "a" && c <= "z") ? c - 8'd32 : c;
    endfunction

    function automatic asl_out_t mk(input logic k, input tok_type_t ty, input logic [7:0] tx,
                                    input logic [31:0] v, input logic [23:0] ln,
                                    input logic tr);
        asl_out_t r;
        r.kind          = k;
        r.token_type    = ty;
        r.text_byte     = tx;
        r.token_value   = v;
        r.line_number   = ln;
        r.was_truncated = tr;
        r.last_of_run   = 1'b0;
        return r;
    endfunction

    state_t state_reg, state_next;

    logic       [7:0]  b;
    logic       [7:0]  ub;
    logic       [3:0]  hexd;
    logic              hex_ok;
    logic       [31:0] num_val;
    tok_type_t         id_type;
    logic       [31:0] id_val;
    logic              pre_v, sec_v, tok_v, tok_tr, do_idle;
    tok_type_t         tok_ty;
    logic       [31:0] tok_val;
    asl_out_t          pre, sec;

    always_comb begin
        b       = in_data.source_byte;
        ub      = upper(b);
        num_val = state_reg.neg ? (32'd0 - state_reg.acc) : state_reg.acc;
        id_type = (state_reg.alias_trk >= 4'd8) ? TOK_NUM : TOK_IDENT;
        id_val  = (state_reg.alias_trk >= 4'd8) ? {29'd0, state_reg.alias_trk[2:0]} : 32'd0;
        hex_ok  = 1'b1;
        hexd    = 4'd0;
        if (is_digit(b)) begin
            hexd = b[3:0];
        end else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
            hexd = b[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        state_next = state_reg;
        pre_v      = 1'b0;
        pre        = '0;
        sec_v      = 1'b0;
        sec        = '0;
        tok_v      = 1'b0;
        tok_ty     = TOK_NUM;
        tok_val    = 32'd0;
        tok_tr     = 1'b0;
        do_idle    = 1'b0;

        if (in_data.end_of_input) begin
            if (!state_reg.err) begin
                case (state_reg.mode)
                    M_CHR_OPEN: begin
                        tok_v   = 1'b1;
                        tok_val = 32'hFFFFFFFF;
                    end
                    M_CHR_ESC, M_CHR_CLOSE: begin
                        tok_v   = 1'b1;
                        tok_val = state_reg.acc;
                    end
                    M_STR, M_STR_ESC: begin
                        tok_v  = 1'b1;
                        tok_ty = TOK_STR;
                    end
                    M_STR_SKIP: begin
                        tok_v  = 1'b1;
                        tok_ty = TOK_STR;
                        tok_tr = 1'b1;
                    end
                    M_IDENT: begin
                        tok_v   = 1'b1;
                        tok_ty  = id_type;
                        tok_val = id_val;
                    end
                    M_NUM_SIGN, M_NUM_ZERO, M_NUM_DEC, M_NUM_HEX: begin
                        tok_v   = 1'b1;
                        tok_val = num_val;
                    end
                    default: ;
                endcase
            end
        end else if (!state_reg.err) begin
            case (state_reg.mode)
                M_COMMENT: begin
                    if (b == 8'h0A) do_idle = 1'b1;
                end
                M_CHR_OPEN: begin
                    state_next.acc  = (b == "\\") ? 32'd92 : {24'd0, b};
                    state_next.mode = (b == "\\") ? M_CHR_ESC : M_CHR_CLOSE;
                end
                M_CHR_ESC: begin
                    if (b == "n") state_next.acc = 32'd10;
                    else if (b == "0") state_next.acc = 32'd0;
                    state_next.mode = M_CHR_CLOSE;
                end
                M_CHR_CLOSE: begin
                    tok_v   = 1'b1;
                    tok_val = state_reg.acc;
                end
                M_STR: begin
                    if (b == "\"") begin
                        tok_v  = 1'b1;
                        tok_ty = TOK_STR;
                    end else if (state_reg.tlen >= 8'(STRING_MAX)) begin
                        state_next.mode = M_STR_SKIP;
                    end else if (b == "\\") begin
                        state_next.mode = M_STR_ESC;
                    end else begin
                        state_next.tlen = state_reg.tlen + 8'd1;
                        pre_v = 1'b1;
                        pre   = mk(1'b0, TOK_STR, b, 32'd0, state_reg.start_line, 1'b0);
                    end
                end
                M_STR_ESC: begin
                    state_next.tlen = state_reg.tlen + 8'd1;
                    state_next.mode = M_STR;
                    pre_v = 1'b1;
                    pre   = mk(1'b0, TOK_STR,
                               (b == "n") ? 8'd10 : ((b == "t") ? 8'd9 : b),
                               32'd0, state_reg.start_line, 1'b0);
                end
                M_STR_SKIP: begin
                    if (b == "\"") begin
                        tok_v  = 1'b1;
                        tok_ty = TOK_STR;
                        tok_tr = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_ident(b) && state_reg.tlen < 8'(IDENT_MAX)) begin
                        state_next.alias_trk = (state_reg.alias_trk == 4'd1 &&
                                                b >= "0" && b <= "7") ?
                                               {1'b1, b[2:0]} : 4'd0;
                        state_next.tlen = state_reg.tlen + 8'd1;
                        pre_v = 1'b1;
                        pre   = mk(1'b0, TOK_IDENT, ub, 32'd0, state_reg.start_line, 1'b0);
                    end else if (b == ":") begin
                        tok_v  = 1'b1;
                        tok_ty = TOK_LABEL;
                    end else begin
                        tok_v   = 1'b1;
                        tok_ty  = id_type;
                        tok_val = id_val;
                        do_idle = 1'b1;
                    end
                end
                M_NUM_SIGN, M_NUM_ZERO: begin
                    if (b == "0" && state_reg.mode == M_NUM_SIGN) begin
                        state_next.mode = M_NUM_ZERO;
                    end else if ((b == "x" || b == "X") && state_reg.mode == M_NUM_ZERO) begin
                        state_next.mode = M_NUM_HEX;
                        state_next.acc  = 32'd0;
                    end else if (is_digit(b)) begin
                        state_next.mode = M_NUM_DEC;
                        state_next.acc  = {28'd0, b[3:0]};
                    end else begin
                        tok_v   = 1'b1;
                        tok_val = num_val;
                        do_idle = 1'b1;
                    end
                end
                M_NUM_DEC: begin
                    if (is_digit(b)) begin
                        state_next.acc = (state_reg.acc << 3) + (state_reg.acc << 1)
                                         + {28'd0, b[3:0]};
                    end else begin
                        tok_v   = 1'b1;
                        tok_val = num_val;
                        do_idle = 1'b1;
                    end
                end
                M_NUM_HEX: begin
                    if (hex_ok) begin
                        state_next.acc = {state_reg.acc[27:0], hexd};
                    end else begin
                        tok_v   = 1'b1;
                        tok_val = num_val;
                        do_idle = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase
        end

        if (tok_v) begin
            pre_v            = 1'b1;
            pre              = mk(1'b1, tok_ty, 8'd0, tok_val, state_reg.start_line, tok_tr);
            state_next.total = state_reg.total + 32'd1;
            state_next.mode  = M_IDLE;
        end

        if (in_data.end_of_input) begin
            sec_v = 1'b1;
            if (state_reg.err) begin
                sec = mk(1'b1, TOK_ERR, 8'd0, 32'd0, state_reg.cur_line, 1'b0);
            end else begin
                sec = mk(1'b1, TOK_END, 8'd0, state_next.total, state_reg.cur_line, 1'b0);
            end
            state_next = RESET_STATE;
        end else if (do_idle) begin
            state_next.mode       = M_IDLE;
            state_next.start_line = state_reg.cur_line;
            if (b == 8'h0A) begin
                if (state_reg.cur_line != LINE_MAX) begin
                    state_next.cur_line = state_reg.cur_line + 24'd1;
                end
            end else if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
                state_next.mode = M_IDLE;
            end else if (b == ";") begin
                state_next.mode = M_COMMENT;
            end else if (b == "'") begin
                state_next.mode = M_CHR_OPEN;
            end else if (b == "\"") begin
                state_next.mode = M_STR;
                state_next.tlen = 8'd0;
            end else if (is_alpha(b) || b == "_" || b == ".") begin
                state_next.mode      = M_IDENT;
                state_next.tlen      = 8'd1;
                state_next.alias_trk = (ub == "R") ? 4'd1 : 4'd0;
                sec_v = 1'b1;
                sec   = mk(1'b0, TOK_IDENT, ub, 32'd0, state_reg.cur_line, 1'b0);
            end else if (is_digit(b) || b == "-") begin
                state_next.neg = (b == "-");
                state_next.acc = 32'd0;
                if (b == "-") begin
                    state_next.mode = M_NUM_SIGN;
                end else if (b == "0") begin
                    state_next.mode = M_NUM_ZERO;
                end else begin
                    state_next.mode = M_NUM_DEC;
                    state_next.acc  = {28'd0, b[3:0]};
                end
            end else begin
                state_next.err = 1'b1;
                sec_v = 1'b1;
                sec   = mk(1'b1, TOK_ERR, 8'd0, 32'd0, state_reg.cur_line, 1'b0);
            end
        end
    end

    always_comb begin
        push = '0;
        if (step) begin
            if (pre_v) begin
                push.r0  = pre;
                push.r1  = sec;
                push.cnt = sec_v ? 2'd2 : 2'd1;
            end else begin
                push.r0  = sec;
                push.cnt = {1'b0, sec_v};
            end
            if (push.cnt == 2'd2) push.r1.last_of_run = 1'b1;
            else push.r0.last_of_run = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= RESET_STATE;
        end else if (step) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/asl_outq.sv =====
// asl_outq: small result queue, takes up to two results per cycle, gives one
// flip-flop entries, registered head
// depends on asl_pkg
module asl_outq (
    input  logic               aclk,
    input  logic               aresetn,
    input  asl_pkg::asl_push_t push,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output asl_pkg::asl_out_t  m_data
);
    import asl_pkg::*;

    localparam int PW = $clog2(OUTQ_DEPTH);
    localparam int CW = $clog2(OUTQ_DEPTH + 1);

    asl_out_t          mem_reg [OUTQ_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pop;
    logic [PW-1:0]     wr_ptr_p1;

    assign m_valid   = (count_reg != '0);
    assign m_data    = mem_reg[rd_ptr_reg];
    assign pop       = m_valid && m_ready;
    assign room      = (count_reg <= CW'(OUTQ_DEPTH - 2));
    assign wr_ptr_p1 = wr_ptr_reg + PW'(1);

    always_comb begin
        wr_ptr_next = wr_ptr_reg + PW'(push.cnt);
        rd_ptr_next = rd_ptr_reg + PW'(pop);
        count_next  = count_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.cnt != 2'd0) mem_reg[wr_ptr_reg] <= push.r0;
        if (push.cnt == 2'd2) mem_reg[wr_ptr_p1] <= push.r1;
    end

endmodule

// ===== rtl/assembly_source_lexer_top.sv =====
// assembly_source_lexer_top: streaming assembly source lexer
// input register, lexer core and result queue
// depends on asl_pkg, asl_core, asl_outq
//
// usage: source bytes enter on the s_ channel, one byte per transfer, with
// end_of_input marking the end of a source. results leave on the m_ channel,
// one per transfer: text characters of strings and identifiers (kind 0) and
// completed tokens (kind 1); last_of_run flags the final result of a byte.
// a byte is taken into the input register, lexed once the queue has two free
// entries, and its results registered in a four-entry queue whose head drives
// m_. one byte is accepted per cycle while each byte yields at most one
// result and m_ready stays high; a byte yielding two results needs two
// transfers on m_, since the queue has a single result port.
// when the receiver stalls, the queue fills and s_ready drops once fewer
// than two entries are free; nothing is lost. reset returns the lexer to
// idle at line one with a zero token count and empties the queue.
module assembly_source_lexer_top #(
    parameter int STRING_MAX = asl_pkg::STRING_MAX_DEF,
    parameter int IDENT_MAX  = asl_pkg::IDENT_MAX_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  asl_pkg::asl_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output asl_pkg::asl_out_t m_data
);
    import asl_pkg::*;

    asl_in_t   in_data_reg;
    logic      in_valid_reg;
    logic      room;
    logic      step;
    asl_push_t push;

    assign step    = in_valid_reg && room;
    assign s_ready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_data_reg <= s_data;
    end

    asl_core #(
        .STRING_MAX (STRING_MAX),
        .IDENT_MAX  (IDENT_MAX)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_data (in_data_reg),
        .push    (push)
    );

    asl_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
